### hdl/tes_pkg.sv
package tes_pkg;

  // sizing
  localparam int DELIM_SLOTS  = 8;
  localparam int OFFSET_WIDTH = 16;
  localparam int DELIM_W      = DELIM_SLOTS * 8;
  localparam int POS_W        = OFFSET_WIDTH + 1;  // holds 0 .. 2^OFFSET_WIDTH
  localparam int BASE_W       = OFFSET_WIDTH + 2;  // position plus up to two
  localparam int LINE_W       = 32;
  localparam int CNT_W        = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_SET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_COUNT = 2'd1;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_DOUBLE = 2'd1,
    QM_SINGLE = 2'd2
  } qmode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
    logic       stop_on_newline;
  } item_t;

  typedef struct packed {
    logic [OFFSET_WIDTH-1:0] token_length;
    logic                    escape_seen;
    logic [LINE_W-1:0]       line_count_now;
    logic                    length_saturated;
  } result_t;

endpackage

### hdl/tes_delim_match.sv
module tes_delim_match (
  input  logic [tes_pkg::DELIM_W-1:0] delim_set,
  input  logic [tes_pkg::CNT_W-1:0]   delim_count,
  input  logic [7:0]                  ch,
  output logic                        hit
);
  import tes_pkg::*;

  // a slot is live while below the count and neither it nor an earlier byte is zero
  always_comb begin
    logic       live;
    logic [7:0] b;
    live = 1'b1;
    hit  = 1'b0;
    for (int k = 0; k < DELIM_SLOTS; k++) begin
      b    = delim_set[8*k +: 8];
      live = live && (delim_count > CNT_W'(k)) && (b != CH_NUL);
      if (live && (b == ch)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

### hdl/tes_scan_core.sv
module tes_scan_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tes_pkg::item_t                item,
  input  logic                          fire,
  input  logic [tes_pkg::DELIM_W-1:0]   delim_set,
  input  logic [tes_pkg::CNT_W-1:0]     delim_count,
  output logic                          res_hit,
  output tes_pkg::result_t              res
);
  import tes_pkg::*;

  localparam logic [BASE_W-1:0] CAP = BASE_W'(1) << OFFSET_WIDTH;

  logic              active_r, active_nxt;
  logic              skip_r, skip_nxt;
  logic              esc_r, esc_nxt;
  logic              nl_r, nl_nxt;
  logic              comment_r, comment_nxt;
  qmode_t            qm_r, qm_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        cur_r, cur_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  logic              cur_delim, ch_delim;
  logic [7:0]        quote_ch;
  logic [BASE_W-1:0] base, len_sum;
  logic [1:0]        fin_add;
  logic              line_inc;

  tes_delim_match u_match_cur (
    .delim_set   (delim_set),
    .delim_count (delim_count),
    .ch          (cur_r),
    .hit         (cur_delim)
  );

  tes_delim_match u_match_ch (
    .delim_set   (delim_set),
    .delim_count (delim_count),
    .ch          (item.ch),
    .hit         (ch_delim)
  );

  function automatic logic [POS_W-1:0] sat_pos(input logic [BASE_W-1:0] v);
    sat_pos = (v > CAP) ? CAP[POS_W-1:0] : v[POS_W-1:0];
  endfunction

  assign quote_ch = (qm_r == QM_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    active_nxt  = active_r;
    skip_nxt    = skip_r;
    esc_nxt     = esc_r;
    nl_nxt      = nl_r;
    comment_nxt = comment_r;
    qm_nxt      = qm_r;
    pos_nxt     = pos_r;
    cur_nxt     = cur_r;
    res_hit     = 1'b0;
    fin_add     = 2'd0;
    line_inc    = 1'b0;
    base        = {1'b0, pos_r};

    if (item.start_req) begin
      active_nxt  = 1'b1;
      skip_nxt    = 1'b0;
      esc_nxt     = 1'b0;
      nl_nxt      = item.stop_on_newline;
      comment_nxt = (item.ch == CH_SLASH);
      qm_nxt      = (item.ch == CH_DQUOTE) ? QM_DOUBLE :
                    (item.ch == CH_SQUOTE) ? QM_SINGLE : QM_NONE;
      pos_nxt     = '0;
      cur_nxt     = item.ch;
      base        = '0;
      if (item.ch == CH_NUL) begin
        res_hit = 1'b1;
      end else if (item.ch == CH_LF) begin
        if (item.stop_on_newline) res_hit = 1'b1;
        else                      line_inc = 1'b1;
      end
    end else if (active_r) begin
      cur_nxt  = item.ch;
      skip_nxt = 1'b0;
      if (skip_r && (item.ch == quote_ch)) begin
        // escaped quote: step over backslash and quote together
        esc_nxt = 1'b1;
        pos_nxt = sat_pos(base + BASE_W'(2));
      end else begin
        if (skip_r) base = base + BASE_W'(1);
        pos_nxt = sat_pos(base);
        if (item.ch == CH_NUL) begin
          res_hit = 1'b1;
          fin_add = 2'd1;
        end else if (qm_r != QM_NONE) begin
          if (item.ch == CH_BSLASH) begin
            skip_nxt = 1'b1;
          end else if (item.ch == quote_ch) begin
            res_hit = 1'b1;
            fin_add = 2'd2;
          end else begin
            pos_nxt = sat_pos(base + BASE_W'(1));
            if (item.ch == CH_LF) begin
              if (nl_r) begin
                res_hit = 1'b1;
                fin_add = 2'd1;
              end else begin
                line_inc = 1'b1;
              end
            end
          end
        end else begin
          if (item.ch == CH_DQUOTE) begin
            qm_nxt = QM_DOUBLE;
            if (cur_delim) begin
              res_hit = 1'b1;
              fin_add = 2'd1;
            end else begin
              pos_nxt = sat_pos(base + BASE_W'(1));
            end
          end else if ((item.ch == CH_SPACE) || (item.ch == CH_TAB) ||
                       (item.ch == CH_CR) || (item.ch == CH_LF)) begin
            res_hit = 1'b1;
            fin_add = 2'd1;
          end else if (comment_r && (base == '0) &&
                       ((item.ch == CH_SLASH) || (item.ch == CH_STAR))) begin
            res_hit = 1'b1;
            fin_add = 2'd1;
          end else if (cur_delim) begin
            res_hit = 1'b1;
            fin_add = 2'd1;
          end else begin
            pos_nxt = sat_pos(base + BASE_W'(1));
            if (ch_delim) begin
              res_hit = 1'b1;
              fin_add = 2'd1;
            end
          end
        end
      end
    end

    if (res_hit) begin
      active_nxt = 1'b0;
      skip_nxt   = 1'b0;
    end

    line_nxt = line_r + LINE_W'(line_inc);
    len_sum  = base + BASE_W'(fin_add);

    res.length_saturated = (len_sum[BASE_W-1:OFFSET_WIDTH] != '0);
    res.token_length     = res.length_saturated ? {OFFSET_WIDTH{1'b1}}
                                                : len_sum[OFFSET_WIDTH-1:0];
    res.escape_seen      = esc_nxt;
    res.line_count_now   = line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      skip_r    <= 1'b0;
      esc_r     <= 1'b0;
      nl_r      <= 1'b0;
      comment_r <= 1'b0;
      qm_r      <= QM_NONE;
      pos_r     <= '0;
      cur_r     <= CH_NUL;
      line_r    <= '0;
    end else if (fire) begin
      active_r  <= active_nxt;
      skip_r    <= skip_nxt;
      esc_r     <= esc_nxt;
      nl_r      <= nl_nxt;
      comment_r <= comment_nxt;
      qm_r      <= qm_nxt;
      pos_r     <= pos_nxt;
      cur_r     <= cur_nxt;
      line_r    <= line_nxt;
    end
  end

endmodule

### hdl/token_end_scanner.sv
// Channel   Direction  Handshake              Payload
// in_       sink       in_valid / in_stall    in_ch, in_start_req, in_stop_on_newline
// out_      source     out_valid / out_stall  out_token_length, out_escape_seen,
//                                             out_line_count_now, out_length_saturated
// cfg_      sink       cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// One character per cycle sustained while in_stall stays low; the transaction that
// ends the token passes through the input register, then the single-pass scan
// logic into the output register, from which the result leaves.
// rst_n is synchronous, active low: scan idle, line counter and delimiters zero.
// in_stall rises only while the input register holds a token-ending character
// and the output register is full and stalled.
// cfg_ready is always high.
module token_end_scanner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_ch,
  input  logic                                in_start_req,
  input  logic                                in_stop_on_newline,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tes_pkg::OFFSET_WIDTH-1:0]    out_token_length,
  output logic                                out_escape_seen,
  output logic [tes_pkg::LINE_W-1:0]          out_line_count_now,
  output logic                                out_length_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tes_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tes_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tes_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0] delim_set_r;
  logic [CNT_W-1:0]      delim_count_r;

  // input register
  logic    in_v_r;
  item_t   in_item_r;

  // output register
  logic    out_v_r;
  result_t out_res_r;

  logic    res_hit;
  result_t res;
  logic    out_free;
  logic    fire;
  logic    in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_set_r   <= '0;
      delim_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELIM_SET:   delim_set_r   <= cfg_wdata;
        CFG_DELIM_COUNT: delim_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // the held character moves on unless its result has nowhere to go
  assign out_free = !out_v_r || !out_stall;
  assign fire     = in_v_r && (!res_hit || out_free);
  assign in_stall = in_v_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.ch              <= in_ch;
      in_item_r.start_req       <= in_start_req;
      in_item_r.stop_on_newline <= in_stop_on_newline;
    end
  end

  tes_scan_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (in_item_r),
    .fire        (fire),
    .delim_set   (delim_set_r[DELIM_W-1:0]),
    .delim_count (delim_count_r),
    .res_hit     (res_hit),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && res_hit) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_hit) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_v_r;
  assign out_token_length     = out_res_r.token_length;
  assign out_escape_seen      = out_res_r.escape_seen;
  assign out_line_count_now   = out_res_r.line_count_now;
  assign out_length_saturated = out_res_r.length_saturated;

endmodule

### hdl/tes_checker.sv
module tes_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [tes_pkg::OFFSET_WIDTH-1:0] out_token_length,
  input logic                             out_escape_seen,
  input logic [tes_pkg::LINE_W-1:0]       out_line_count_now,
  input logic                             out_length_saturated
);
  import tes_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_length) &&
      $stable(out_escape_seen) && $stable(out_line_count_now) &&
      $stable(out_length_saturated))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_sat_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length_saturated |-> out_token_length == {OFFSET_WIDTH{1'b1}})
    else $error("saturated length not at top of range");

  // an escaped quote steps over two characters
  a_esc_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_escape_seen |-> out_token_length >= OFFSET_WIDTH'(2))
    else $error("escape flag on a short token");

  a_empty_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_length == '0) |-> !out_escape_seen)
    else $error("escape flag on an empty token");

endmodule

bind token_end_scanner tes_checker u_chk (.*);

### test/token_end_scanner_checker.sv
`timescale 1ns / 1ps

module token_end_scanner_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [7:0]                       in_ch,
  input  logic                             in_start_req,
  input  logic                             in_stop_on_newline,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [tes_pkg::OFFSET_WIDTH-1:0] out_token_length,
  input  logic                             out_escape_seen,
  input  logic [tes_pkg::LINE_W-1:0]       out_line_count_now,
  input  logic                             out_length_saturated,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tes_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int unsigned                      mismatches,
  output int unsigned                      outstanding,
  output int unsigned                      live_items
);
  import tes_pkg::*;

  localparam logic [BASE_W-1:0] LEN_MAX = BASE_W'((1 << OFFSET_WIDTH) - 1);
  localparam logic [BASE_W-1:0] POS_CAP = BASE_W'(1 << OFFSET_WIDTH);

  // own copy of the registers and scan state
  logic [DELIM_W-1:0] delim_bytes;
  logic [CNT_W-1:0]   delim_used;
  logic [7:0]         cur_ch;
  logic [7:0]         held_bs;
  logic [POS_W-1:0]   pos;
  qmode_t             qmode;
  logic               skip_next;
  logic               esc_seen;
  logic               scanning;
  logic               nl_stops;
  logic               comment_tok;
  logic [LINE_W-1:0]  lines;
  int unsigned        live_tally;

  result_t            token_ends_due[$];

  task automatic flag_mismatch(input string what);
    $display("[%0t] token end mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic is_delimiter(input logic [7:0] c);
    int n;
    int k;
    n = (delim_used > DELIM_SLOTS) ? DELIM_SLOTS : int'(delim_used);
    for (k = 0; k < n; k++) begin
      if (delim_bytes[8*k +: 8] == CH_NUL)
        return 1'b0;
      if (delim_bytes[8*k +: 8] == c)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // position sticks one past the offset range once it gets there
  function automatic void advance(input logic [1:0] k);
    logic [BASE_W-1:0] nxt;
    nxt = BASE_W'(pos) + BASE_W'(k);
    if (nxt > POS_CAP)
      nxt = POS_CAP;
    pos = nxt[POS_W-1:0];
  endfunction

  function automatic logic end_token(input logic [1:0] extra);
    logic [BASE_W-1:0] span;
    logic              sat;
    result_t           r;
    span = BASE_W'(pos) + BASE_W'(extra);
    sat = (span > LEN_MAX);
    r.token_length     = sat ? '1 : span[OFFSET_WIDTH-1:0];
    r.escape_seen      = esc_seen;
    r.line_count_now   = lines;
    r.length_saturated = sat;
    token_ends_due.push_back(r);
    scanning  = 1'b0;
    skip_next = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic enter_char(input logic [7:0] c);
    cur_ch = c;
    if (c == CH_LF) begin
      if (nl_stops)
        return end_token(2'd0);
      lines = lines + 32'd1;
    end
    if (pos != '0 && qmode == QM_NONE && is_delimiter(c))
      return end_token(2'd0);
    return 1'b0;
  endfunction

  function automatic logic judge_next(input logic [7:0] n);
    logic [7:0] c;
    logic [7:0] q;
    c = cur_ch;
    if (n == CH_NUL)
      return end_token(2'd1);
    if (qmode != QM_NONE) begin
      q = (qmode == QM_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
      if (n == CH_BSLASH) begin
        skip_next = 1'b1;
        held_bs = n;
        return 1'b0;
      end
      if (n == q)
        return end_token(2'd2);
    end else begin
      if (n == CH_DQUOTE) begin
        qmode = QM_DOUBLE;
        // delimiter right before an opening quote: end one past it
        if (is_delimiter(c))
          return end_token(2'd1);
        advance(2'd1);
        return enter_char(n);
      end
      if (n == CH_SPACE || n == CH_TAB || n == CH_CR || n == CH_LF)
        return end_token(2'd1);
      if (comment_tok && pos == '0 && (n == CH_SLASH || n == CH_STAR))
        return end_token(2'd1);
      if (is_delimiter(c))
        return end_token(2'd1);
    end
    advance(2'd1);
    return enter_char(n);
  endfunction

  // one accepted character through the scan
  function automatic void scan_char(input logic [7:0] c, input logic start, input logic nl);
    logic [7:0] q;
    if (start) begin
      live_tally++;
      scanning    = 1'b1;
      pos         = '0;
      esc_seen    = 1'b0;
      skip_next   = 1'b0;
      nl_stops    = nl;
      qmode       = (c == CH_DQUOTE) ? QM_DOUBLE : ((c == CH_SQUOTE) ? QM_SINGLE : QM_NONE);
      comment_tok = (c == CH_SLASH);
      cur_ch      = c;
      held_bs     = CH_NUL;
      if (c == CH_NUL)
        void'(end_token(2'd0));
      else
        void'(enter_char(c));
    end else if (scanning) begin
      live_tally++;
      if (skip_next) begin
        q = (qmode == QM_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
        skip_next = 1'b0;
        if (c == q) begin
          esc_seen = 1'b1;
          advance(2'd2);
          void'(enter_char(c));
        end else begin
          advance(2'd1);
          if (!enter_char(held_bs))
            void'(judge_next(c));
        end
      end else begin
        void'(judge_next(c));
      end
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      delim_bytes = '0;
      delim_used  = '0;
      cur_ch      = CH_NUL;
      held_bs     = CH_NUL;
      pos         = '0;
      qmode       = QM_NONE;
      skip_next   = 1'b0;
      esc_seen    = 1'b0;
      scanning    = 1'b0;
      nl_stops    = 1'b0;
      comment_tok = 1'b0;
      lines       = '0;
      live_tally  = 0;
      token_ends_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DELIM_SET:   delim_bytes = cfg_wdata;
          CFG_DELIM_COUNT: delim_used  = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        scan_char(in_ch, in_start_req, in_stop_on_newline);
      if (out_valid && !out_stall) begin
        if (token_ends_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, length %0d", out_token_length));
        end else begin
          want = token_ends_due.pop_front();
          if (out_token_length !== want.token_length)
            flag_mismatch($sformatf("token_length %0d, want %0d",
                                    out_token_length, want.token_length));
          if (out_escape_seen !== want.escape_seen)
            flag_mismatch($sformatf("escape_seen %b, want %b",
                                    out_escape_seen, want.escape_seen));
          if (out_line_count_now !== want.line_count_now)
            flag_mismatch($sformatf("line_count_now %0d, want %0d",
                                    out_line_count_now, want.line_count_now));
          if (out_length_saturated !== want.length_saturated)
            flag_mismatch($sformatf("length_saturated %b, want %b",
                                    out_length_saturated, want.length_saturated));
        end
      end
    end
    outstanding <= token_ends_due.size();
    live_items  <= live_tally;
  end

endmodule

### test/token_end_scanner_tb.sv
`timescale 1ns / 1ps

// Drives character transactions into the token end scanner and leaves all
// prediction and comparison to the checker alongside it. The top only makes
// stimulus, holds the watchdog and gives the verdict.
module token_end_scanner_tb;
  import tes_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int          PHASES         = 6;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              in_ch;
  logic                    in_start_req;
  logic                    in_stop_on_newline;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [OFFSET_WIDTH-1:0] out_token_length;
  logic                    out_escape_seen;
  logic [LINE_W-1:0]       out_line_count_now;
  logic                    out_length_saturated;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned live_items;
  int unsigned quiet_cycles = 0;

  // idling knobs, percent chance per transaction / per cycle
  int unsigned in_gap_pct = 0;
  int unsigned stall_pct  = 0;

  // what the delimiter registers currently hold, for picking stimulus
  logic [DELIM_W-1:0] cur_set;
  logic [CNT_W-1:0]   cur_count;

  token_end_scanner u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_ch                (in_ch),
    .in_start_req         (in_start_req),
    .in_stop_on_newline   (in_stop_on_newline),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_token_length     (out_token_length),
    .out_escape_seen      (out_escape_seen),
    .out_line_count_now   (out_line_count_now),
    .out_length_saturated (out_length_saturated),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  token_end_scanner_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_ch                (in_ch),
    .in_start_req         (in_start_req),
    .in_stop_on_newline   (in_stop_on_newline),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_token_length     (out_token_length),
    .out_escape_seen      (out_escape_seen),
    .out_line_count_now   (out_line_count_now),
    .out_length_saturated (out_length_saturated),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .mismatches           (mismatches),
    .outstanding          (outstanding),
    .live_items           (live_items)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver back-pressure: out_stall is raised in bursts. A burst only
  // starts on a fresh edge, so out_stall never sees two updates in one step.
  always begin
    @(posedge clk);
    if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Watchdog: counts cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAIL token_end_scanner");
    $finish;
  end

  // One character transaction. Called just after a rising edge; the payload
  // holds until the edge that accepts it. The handshake is sampled on the
  // pre-edge values, same as the checker sees it.
  task automatic send_char(input logic [7:0] c, input logic start, input logic nl);
    in_valid           <= 1'b1;
    in_ch              <= c;
    in_start_req       <= start;
    in_stop_on_newline <= nl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // a whole token from a string: first character opens the scan
  task automatic send_str(input string s, input logic nl);
    int i;
    for (i = 0; i < s.len(); i++)
      send_char(s[i], (i == 0), nl);
  endtask

  // Sender holds off until the checker has nothing left waiting, then lets
  // the pipeline settle. The extra edge first lets the checker count the
  // last transaction before outstanding is looked at.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delims(input logic [DELIM_W-1:0] set, input logic [CNT_W-1:0] count);
    cur_set   = set;
    cur_count = count;
    write_reg(CFG_DELIM_SET, set);
    write_reg(CFG_DELIM_COUNT, {{(CFG_DATA_W-CNT_W){1'b0}}, count});
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(97, 122));  // a..z
      1:       return 8'($urandom_range(65, 90));   // A..Z
      default: return 8'($urandom_range(48, 57));   // 0..9
    endcase
  endfunction

  // any slot up to the count, bytes past a zero included
  function automatic logic [7:0] delim_char();
    int k;
    k = $urandom_range(((cur_count > DELIM_SLOTS) ? DELIM_SLOTS : int'(cur_count)) - 1);
    return cur_set[8*k +: 8];
  endfunction

  // Mostly word characters, with enough quotes, backslashes and terminators
  // to get into the quoted and escaped paths; a slice of raw bytes too.
  function automatic logic [7:0] script_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return word_char();
    if (roll < 58) return CH_DQUOTE;
    if (roll < 61) return CH_SQUOTE;
    if (roll < 69) return CH_BSLASH;
    if (roll < 74) return (cur_count != 0) ? delim_char() : word_char();
    if (roll < 78) return roll[0] ? CH_SLASH : CH_STAR;
    if (roll < 81) return CH_LF;
    if (roll < 85) return (roll == 81) ? CH_TAB : ((roll == 82) ? CH_CR : CH_SPACE);
    if (roll < 87) return CH_NUL;
    return 8'($urandom_range(255));
  endfunction

  // A well-formed scan: an opening character biased to quotes and slashes,
  // a body of mostly short length with the odd restart, then a terminator.
  task automatic send_token();
    int unsigned roll;
    int unsigned body;
    logic        nl;
    logic [7:0]  first;
    roll = $urandom_range(99);
    nl   = 1'($urandom_range(1));
    if (roll < 25)      first = CH_DQUOTE;
    else if (roll < 35) first = CH_SQUOTE;
    else if (roll < 45) first = CH_SLASH;
    else if (roll < 48) first = CH_NUL;
    else if (roll < 52) first = CH_LF;
    else                first = script_char();
    send_char(first, 1'b1, nl);
    roll = $urandom_range(99);
    if (roll < 70)      body = $urandom_range(8);
    else if (roll < 95) body = $urandom_range(9, 30);
    else                body = $urandom_range(31, 200);
    repeat (body)
      send_char(script_char(), ($urandom_range(49) == 0), 1'($urandom_range(1)));
    case ($urandom_range(3))
      0:       send_char(CH_SPACE, 1'b0, 1'b0);
      1:       send_char(CH_NUL, 1'b0, 1'b0);
      2:       send_char(CH_LF, 1'b0, 1'b1);
      default: send_char(CH_DQUOTE, 1'b0, 1'b0);
    endcase
  endtask

  initial begin : stimulus
    int unsigned    tokens;
    int unsigned    base;
    int             ph;
    int             k;
    logic [DELIM_W-1:0] rand_set;

    in_valid           <= 1'b0;
    in_ch              <= CH_NUL;
    in_start_req       <= 1'b0;
    in_stop_on_newline <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_index          <= CFG_DELIM_SET;
    cfg_wdata          <= '0;
    rst_n              <= 1'b0;
    cur_set   = '0;
    cur_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: ',' and ';' as delimiters, no idling ---
    set_delims(64'h3B2C, 4'd2);
    send_char(CH_NUL, 1'b1, 1'b0);      // empty string, length zero at once
    send_str("ab ", 1'b0);              // plain word ended by a blank
    send_str("//", 1'b0);               // line comment opener
    send_str("/*", 1'b0);               // block comment opener
    send_str("'x'", 1'b0);              // single quote opened by the first character
    send_str("a'b ", 1'b0);             // later single quote does not open
    send_str("\"a\\\"b\"", 1'b0);       // escaped quote inside double quotes
    send_str("a,", 1'b0);               // delimiter met on entry
    send_str(",\"", 1'b0);              // delimiter in front of an opening quote
    send_char(CH_LF, 1'b1, 1'b1);       // newline stop on the very first character
    send_str("\"a\nb\"", 1'b1);         // newline stop inside quotes
    send_str("a", 1'b0);                // dropped by the restart below
    send_str("c ", 1'b0);
    send_char("z", 1'b0, 1'b0);         // idle character, ignored
    drain();

    // --- random phases, each under its own delimiter setting ---
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_delims(64'h2B3D_7D7B_2928_3B2C, 4'd8);     // all slots used
        1: set_delims({$urandom, $urandom}, 4'd0);        // bytes present, none in use
        2: set_delims(64'h0000_0000_003B_002C, 4'd3);     // zero byte cuts the list short
        3: set_delims(64'h2E3A_7C26_2B2D_3D2C, 4'd12);    // count beyond the slots
        4: set_delims('1, 4'd8);                          // every slot 0xFF
        default: begin
          for (k = 0; k < DELIM_SLOTS; k++)
            rand_set[8*k +: 8] = 8'($urandom_range(33, 126));
          set_delims(rand_set, 4'($urandom_range(8)));
        end
      endcase
      base   = live_items;
      tokens = 0;
      while (live_items - base < RANDOM_ITEMS / PHASES) begin
        // idling settles in stretches; none at all in the closing phase
        if (ph == PHASES - 1) begin
          in_gap_pct = 0;
          stall_pct  = 0;
        end else if (tokens % 40 == 0) begin
          in_gap_pct = (tokens % 120 == 0) ? 0 : $urandom_range(1, 3) * 12;
          stall_pct  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3) * 12;
        end
        if ($urandom_range(9) == 0) begin
          // noise: raw bytes with stray starts
          repeat ($urandom_range(1, 6))
            send_char(8'($urandom_range(255)), ($urandom_range(3) == 0), 1'($urandom_range(1)));
        end else begin
          send_token();
        end
        tokens++;
      end
      send_char(CH_NUL, 1'b1, 1'b0);    // closes any scan left open
      drain();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("PASS token_end_scanner");
    else
      $display("FAIL token_end_scanner");
    $finish;
  end

endmodule

### sim.f
hdl/tes_pkg.sv
hdl/tes_delim_match.sv
hdl/tes_scan_core.sv
hdl/token_end_scanner.sv
hdl/tes_checker.sv
test/token_end_scanner_checker.sv
test/token_end_scanner_tb.sv
